// File: hw/rtl/pcha_pkg.sv
// Package: shared types and constants for the path coverage heatmap accumulator.
package pcha_pkg;

  localparam int CoordWidth = 11;
  localparam int OutWidth = 16;
  localparam logic [6:0] DefaultRadius = 7'd50;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  typedef enum logic [0:0] {
    REG_RADIUS  = 1'b0,
    REG_CONNECT = 1'b1
  } reg_idx_t;

  // One queued command from the front end to the back end
  typedef struct packed {
    req_t                   req;
    logic signed [CoordWidth-1:0] px;
    logic signed [CoordWidth-1:0] py;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_ADDR,
    ST_READ_DATA,
    ST_READ_OUT,
    ST_LINE_STEP,
    ST_BRUSH_ADDR,
    ST_BRUSH_READ,
    ST_BRUSH_WRITE,
    ST_BRUSH_NEXT
  } state_t;

endpackage

// File: hw/rtl/pcha_front.sv
// Front end: input acceptance into a short command queue.
module pcha_front
  import pcha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic q_valid,
  input  logic q_take,
  output cmd_t q_cmd
);

  localparam int Depth = 4;

  cmd_t       slots [Depth];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 3'(Depth));
  assign push = in_valid && in_ready;
  assign q_valid = (fill != 3'd0);
  assign pop = q_take && q_valid;
  assign q_cmd = slots[rptr];

  // Store incoming transactions
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
  end

endmodule

// File: hw/rtl/pcha_back.sv
// Back end: grid memory, line walker and brush stamper.
module pcha_back
  import pcha_pkg::*;
#(
  parameter int GRID_SIZE = 512,
  parameter int MAX_RADIUS = 64,
  parameter int COUNT_WIDTH = 16
)
(
  input  logic clk,
  input  logic rst,
  input  logic [6:0] brush_radius,
  input  logic connect_mode,
  input  logic q_valid,
  output logic q_take,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output logic [OutWidth-1:0] visit_count
);

  localparam int GW = $clog2(GRID_SIZE);
  localparam int AW = 2 * GW;
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int OW = RW + 1;
  localparam int SW = 14;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [RW-1:0] MaxR = RW'(MAX_RADIUS);

  // Power-of-two depth so that the {x, y} address always lands inside the array
  logic [COUNT_WIDTH-1:0] grid [2**AW];
  state_t state;
  state_t state_next;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] addr;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [OutWidth-1:0] out_data;
  logic mem_we;
  logic [COUNT_WIDTH-1:0] wdata;

  logic signed [SW-1:0] prev_x;
  logic signed [SW-1:0] prev_y;
  logic have_prev;

  // Line walker state
  logic signed [SW-1:0] lx, ly, tx, ty;
  logic signed [SW-1:0] ldx, ldy, lerr;
  logic lsx, lsy;
  logic line_mode;

  // Brush state
  logic [RW-1:0] rad;
  logic signed [OW-1:0] bdx, bdy;
  logic [2*OW+1:0] r2;
  logic [2*OW+1:0] sq_sum;
  logic signed [SW-1:0] wx, wy;
  logic in_grid;
  logic covered;

  logic signed [SW-1:0] cx_ext, cy_ext;
  logic read_in;
  logic signed [SW-1:0] e2;
  logic [RW-1:0] rad_sel;

  assign cx_ext = SW'(q_cmd.px);
  assign cy_ext = SW'(q_cmd.py);
  assign read_in = (cx_ext >= 0) && (cx_ext < SW'(GRID_SIZE))
                && (cy_ext >= 0) && (cy_ext < SW'(GRID_SIZE));
  assign rad_sel = (int'(brush_radius) > MAX_RADIUS) ? MaxR : RW'(brush_radius);

  assign wx = lx + SW'(bdx);
  assign wy = ly + SW'(bdy);
  assign in_grid = (wx >= 0) && (wx < SW'(GRID_SIZE))
                && (wy >= 0) && (wy < SW'(GRID_SIZE));
  assign e2 = lerr <<< 1;

  // Squared distance is registered so the compare sees one product per path
  always_ff @(posedge clk) begin
    sq_sum <= (2*OW+2)'(bdx) * (2*OW+2)'(bdx) + (2*OW+2)'(bdy) * (2*OW+2)'(bdy);
  end
  assign covered = (sq_sum < r2);

  // Memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) grid[state == ST_CLEAR ? clr_addr : addr] <= wdata;
    rdata <= grid[addr];
  end

  always_comb begin
    mem_we = 1'b0;
    wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == ST_BRUSH_WRITE && in_grid && covered && rdata != CountMax) begin
      mem_we = 1'b1;
      wdata = rdata + 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.req == REQ_READ) state_next = ST_READ_ADDR;
          else if (have_prev && connect_mode) state_next = ST_LINE_STEP;
          else if (have_prev && rad_sel != '0) state_next = ST_BRUSH_ADDR;
        end
      end
      ST_READ_ADDR: state_next = ST_READ_DATA;
      ST_READ_DATA: state_next = ST_READ_OUT;
      ST_READ_OUT: if (out_ready) state_next = ST_IDLE;
      ST_LINE_STEP: begin
        if (lx == tx && ly == ty) state_next = ST_IDLE;
        else if (rad != '0) state_next = ST_BRUSH_ADDR;
      end
      ST_BRUSH_ADDR: state_next = ST_BRUSH_READ;
      ST_BRUSH_READ: state_next = ST_BRUSH_WRITE;
      ST_BRUSH_WRITE: state_next = ST_BRUSH_NEXT;
      ST_BRUSH_NEXT: begin
        if (bdy == OW'(rad) - 1'b1 && bdx == OW'(rad) - 1'b1)
          state_next = line_mode ? ST_LINE_STEP : ST_IDLE;
        else state_next = ST_BRUSH_ADDR;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_take = (state == ST_IDLE) && q_valid;
    out_valid = (state == ST_READ_OUT);
    visit_count = out_data;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      have_prev <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_IDLE && q_valid) begin
        if (q_cmd.req == REQ_READ) begin
          addr <= read_in ? {cx_ext[GW-1:0], cy_ext[GW-1:0]} : '0;
          line_mode <= 1'b0;
          lx <= read_in ? SW'(1) : SW'(0);
        end else begin
          have_prev <= 1'b1;
          prev_x <= cx_ext;
          prev_y <= cy_ext;
          rad <= rad_sel;
          r2 <= (2*OW+2)'(rad_sel) * (2*OW+2)'(rad_sel);
          line_mode <= connect_mode;
          lx <= prev_x;
          ly <= prev_y;
          tx <= cx_ext;
          ty <= cy_ext;
          ldx <= (cx_ext > prev_x) ? cx_ext - prev_x : prev_x - cx_ext;
          ldy <= (cy_ext > prev_y) ? cy_ext - prev_y : prev_y - cy_ext;
          lerr <= ((cx_ext > prev_x) ? cx_ext - prev_x : prev_x - cx_ext)
                - ((cy_ext > prev_y) ? cy_ext - prev_y : prev_y - cy_ext);
          lsx <= (prev_x < cx_ext);
          lsy <= (prev_y < cy_ext);
          bdx <= -$signed(OW'(rad_sel));
          bdy <= -$signed(OW'(rad_sel));
        end
      end
      if (state == ST_READ_DATA) begin
        out_data <= (lx == SW'(0)) ? '0 :
                    (COUNT_WIDTH > OutWidth && rdata > COUNT_WIDTH'(16'hFFFF)) ?
                    16'hFFFF : OutWidth'(rdata);
      end
      // Brush centred on the current line point, then step the line
      if (state == ST_LINE_STEP) begin
        bdx <= -$signed(OW'(rad));
        bdy <= -$signed(OW'(rad));
      end
      if (state == ST_BRUSH_ADDR) addr <= {wx[GW-1:0], wy[GW-1:0]};
      if (state == ST_BRUSH_NEXT) begin
        if (bdy == OW'(rad) - 1'b1) begin
          bdy <= -$signed(OW'(rad));
          if (bdx == OW'(rad) - 1'b1) begin
            if (line_mode) begin
              if (e2 > -ldy) lx <= lsx ? lx + 1'b1 : lx - 1'b1;
              if (e2 < ldx) ly <= lsy ? ly + 1'b1 : ly - 1'b1;
              lerr <= lerr - ((e2 > -ldy) ? ldy : '0) + ((e2 < ldx) ? ldx : '0);
            end
          end else bdx <= bdx + 1'b1;
        end else bdy <= bdy + 1'b1;
      end
      // Zero radius in line mode: walk without stamping
      if (state == ST_LINE_STEP && rad == '0 && !(lx == tx && ly == ty)) begin
        if (e2 > -ldy) lx <= lsx ? lx + 1'b1 : lx - 1'b1;
        if (e2 < ldx) ly <= lsy ? ly + 1'b1 : ly - 1'b1;
        lerr <= lerr - ((e2 > -ldy) ? ldy : '0) + ((e2 < ldx) ? ldx : '0);
      end
    end
  end

endmodule

// File: hw/rtl/path_coverage_heatmap_accumulator.sv
// Read: a read leaves the queue, passes ST_READ_ADDR, ST_READ_DATA and ST_READ_OUT, and holds the back end
// until out_ready takes its count. Add: after it leaves the queue, each brush offset passes ST_BRUSH_ADDR,
// ST_BRUSH_READ, ST_BRUSH_WRITE and ST_BRUSH_NEXT, (2r)^2 offsets per stamp; in connect mode that per
// line point plus a ST_LINE_STEP pass each. The single grid RAM port sets this pace.
// Reset: synchronous; a clearing pass over all 2^(2*clog2(GRID_SIZE)) grid words (262144 at 512)
// zeroes the grid before the first queued transaction runs. Registers return to defaults.
module path_coverage_heatmap_accumulator
  import pcha_pkg::*;
#(
  parameter int GRID_SIZE = 512,
  parameter int MAX_RADIUS = 64,
  parameter int COUNT_WIDTH = 16
)
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic signed [CoordWidth-1:0] point_x,
  input  logic signed [CoordWidth-1:0] point_y,
  output logic out_valid,
  input  logic out_ready,
  output logic [OutWidth-1:0] visit_count,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [6:0] brush_radius;
  logic connect_mode;
  logic q_valid;
  logic q_take;
  cmd_t q_cmd;
  cmd_t in_cmd;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx = reg_idx_t'(paddr[2]);
  assign in_cmd = '{req: req_t'(req_type), px: point_x, py: point_y};

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      brush_radius <= DefaultRadius;
      connect_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (ridx)
        REG_RADIUS:  brush_radius <= pwdata[6:0];
        REG_CONNECT: connect_mode <= pwdata[0];
      endcase
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (ridx)
        REG_RADIUS:  prdata = {25'd0, brush_radius};
        REG_CONNECT: prdata = {31'd0, connect_mode};
      endcase
    end
  end

  pcha_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );

  pcha_back #(
    .GRID_SIZE(GRID_SIZE), .MAX_RADIUS(MAX_RADIUS), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst), .brush_radius(brush_radius), .connect_mode(connect_mode),
    .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready), .visit_count(visit_count)
  );

endmodule

// File: hw/rtl/pcha_checker.sv
// Checker: port-level properties of the accumulator, with its bind.
module pcha_checker
  import pcha_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [OutWidth-1:0] visit_count,
  input logic pready
);

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visit_count))
    else $error("result changed while stalled");

  // Never show a result straight out of reset
  a_no_out_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // Config port never stalls
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  // The queue comes out of reset empty, so it takes a transaction at once
  a_ready_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("not ready after reset");

endmodule

bind path_coverage_heatmap_accumulator pcha_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .visit_count(visit_count),
  .pready(pready)
);
